// File: rtl/core/prox_card_frame_encoder_defines.svh
// Assertion macros for the card frame encoder.
`ifndef PROX_CARD_FRAME_ENCODER_DEFINES_SVH
`define PROX_CARD_FRAME_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/prox_enc_pkg.sv
// Types and constants shared by the card frame encoder.
package prox_enc_pkg;

  localparam logic [7:0] FMT_26 = 8'd26;
  localparam logic [7:0] FMT_34 = 8'd34;
  localparam logic [7:0] FMT_37 = 8'd37;
  localparam logic [7:0] FMT_50 = 8'd50;

  localparam int FIELD_BITS = 66;
  localparam int FRAME_BITS = 96;
  localparam int GROUPS     = FIELD_BITS / 3;

  localparam logic [7:0] PREAMBLE = 8'b0000_0001;

  typedef struct packed {
    logic [7:0]  format_length;
    logic [31:0] facility;
    logic [31:0] card_number;
  } req_t;

  typedef struct packed {
    logic [5:0]  used_format;
    logic [31:0] frame_word_first;
    logic [31:0] frame_word_middle;
    logic [31:0] frame_word_last;
  } rsp_t;

endpackage

// File: rtl/core/prox_enc_frame.sv
// Combinational frame builder: format normalization, Wiegand word and group parity.
module prox_enc_frame (
  input  prox_enc_pkg::req_t req,
  output prox_enc_pkg::rsp_t rsp
);

  logic [7:0]                          fmt;
  logic [prox_enc_pkg::FIELD_BITS-1:0] field;
  logic [prox_enc_pkg::FRAME_BITS-1:0] frame;

  logic [23:0] d26;
  logic [31:0] d34;
  logic [30:0] d37;
  logic [47:0] d50;

  assign d26 = {req.facility[7:0],  req.card_number[15:0]};
  assign d34 = {req.facility[7:0],  req.card_number[23:0]};
  assign d37 = {req.facility[12:0], req.card_number[17:0]};
  assign d50 = {req.facility[15:0], req.card_number[31:0]};

  // field is MSB-first: format byte, even parity, data, odd parity, zero pad
  always_comb begin
    case (req.format_length)
      prox_enc_pkg::FMT_34: begin
        fmt   = prox_enc_pkg::FMT_34;
        field = {fmt, ^d34[31:16], d34, ~^d34[15:0], 24'd0};
      end
      prox_enc_pkg::FMT_37: begin
        fmt   = prox_enc_pkg::FMT_37;
        field = {fmt, ^d37[30:16], d37, ~^d37[15:1], 25'd0};
      end
      prox_enc_pkg::FMT_50: begin
        fmt   = prox_enc_pkg::FMT_50;
        field = {fmt, ^d50[47:24], d50, ~^d50[23:0], 8'd0};
      end
      default: begin
        fmt   = prox_enc_pkg::FMT_26;
        field = {fmt, ^d26[23:12], d26, ~^d26[11:0], 32'd0};
      end
    endcase
  end

  // odd parity bit after every 3 field bits
  always_comb begin
    frame[prox_enc_pkg::FRAME_BITS-1 -: 8] = prox_enc_pkg::PREAMBLE;
    for (int g = 0; g < prox_enc_pkg::GROUPS; g++) begin
      frame[prox_enc_pkg::FRAME_BITS-9-4*g -: 4] =
        {field[prox_enc_pkg::FIELD_BITS-1-3*g -: 3],
         ~^field[prox_enc_pkg::FIELD_BITS-1-3*g -: 3]};
    end
  end

  assign rsp.used_format       = fmt[5:0];
  assign rsp.frame_word_first  = frame[95:64];
  assign rsp.frame_word_middle = frame[63:32];
  assign rsp.frame_word_last   = frame[31:0];

endmodule

// File: rtl/core/prox_card_frame_encoder.sv
// Proximity card frame encoder top level: request register, frame builder, result register.
// 2 registers (input, result) in the path; the result loads from the input register.
// Throughput: one request per cycle while out_ready is high; the frame builder is a
// single pass of bit placement and short parity trees between the two registers.
// A full result register that is not taken stalls the input register, then in_ready.
// Reset (rst, synchronous, active high) empties both registers; no other state.
`include "prox_card_frame_encoder_defines.svh"

module prox_card_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  format_length,
  input  logic [31:0] facility,
  input  logic [31:0] card_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  used_format,
  output logic [31:0] frame_word_first,
  output logic [31:0] frame_word_middle,
  output logic [31:0] frame_word_last
);

  logic               req_valid;
  prox_enc_pkg::req_t req;
  prox_enc_pkg::rsp_t rsp_next;
  prox_enc_pkg::rsp_t rsp;
  logic               out_open;
  logic               req_move;

  assign out_open = !out_valid || out_ready;
  assign req_move = req_valid && out_open;
  assign in_ready = !req_valid || req_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req.format_length <= format_length;
      req.facility      <= facility;
      req.card_number   <= card_number;
    end
  end

  prox_enc_frame u_frame (
    .req (req),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= req_valid;
    end
    if (req_move) begin
      rsp <= rsp_next;
    end
  end

  assign used_format       = rsp.used_format;
  assign frame_word_first  = rsp.frame_word_first;
  assign frame_word_middle = rsp.frame_word_middle;
  assign frame_word_last   = rsp.frame_word_last;

  `ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, req_valid)
  `ASSERT_NEXT(a_move_fills, clk, rst, req_move, out_valid)
  `ASSERT_IMPL(a_full_stall, clk, rst, req_valid && out_valid && !out_ready, !in_ready)
  `ASSERT_IMPL(a_frame_shape, clk, rst, out_valid,
    frame_word_first[31:24] == prox_enc_pkg::PREAMBLE &&
    (used_format == 6'd26 || used_format == 6'd34 ||
     used_format == 6'd37 || used_format == 6'd50))

endmodule

// File: tb/sv/prox_card_frame_encoder_tb.sv
// Testbench for prox_card_frame_encoder: directed and random requests checked against an in-bench frame encoder.
`timescale 1ns / 1ps

module prox_card_frame_encoder_tb;

  localparam int NUM_RANDOM  = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_PCT    = 38;

  class frame_scoreboard;
    prox_enc_pkg::rsp_t expected_frames[$];
    int                 failures;

    function prox_enc_pkg::rsp_t encode_frame(logic [7:0] fmt, logic [31:0] fc,
                                              logic [31:0] cn);
      logic [7:0]                          fmt_used;
      int                                  fc_bits;
      int                                  cn_bits;
      int                                  n;
      int                                  half;
      int                                  pos;
      logic [63:0]                         data;
      logic [prox_enc_pkg::FIELD_BITS-1:0] field;
      logic [prox_enc_pkg::FRAME_BITS-1:0] frame;
      logic                                even_par;
      logic                                odd_par;
      prox_enc_pkg::rsp_t                  r;
      fmt_used = fmt;
      case (fmt)
        prox_enc_pkg::FMT_34: begin
          fc_bits = 8;
          cn_bits = 24;
        end
        prox_enc_pkg::FMT_37: begin
          fc_bits = 13;
          cn_bits = 18;
        end
        prox_enc_pkg::FMT_50: begin
          fc_bits = 16;
          cn_bits = 32;
        end
        default: begin
          fmt_used = prox_enc_pkg::FMT_26;
          fc_bits  = 8;
          cn_bits  = 16;
        end
      endcase
      n    = fc_bits + cn_bits;
      half = n / 2;
      data = ((64'(fc) & ((64'd1 << fc_bits) - 64'd1)) << cn_bits)
           | (64'(cn) & ((64'd1 << cn_bits) - 64'd1));
      field    = '0;
      even_par = 1'b0;
      odd_par  = 1'b0;
      for (int i = 0; i < 8; i++) field[i] = fmt_used[7-i];
      for (int i = 0; i < n; i++) begin
        field[9+i] = data[n-1-i];
        if (i < half) even_par ^= data[n-1-i];
        else if (i < 2 * half) odd_par ^= data[n-1-i];
      end
      field[8]   = even_par;
      field[9+n] = ~odd_par;
      frame = '0;
      for (int i = 0; i < 8; i++)
        frame[prox_enc_pkg::FRAME_BITS-1-i] = prox_enc_pkg::PREAMBLE[7-i];
      pos = 8;
      for (int g = 0; g < prox_enc_pkg::FIELD_BITS; g += 3) begin
        for (int k = 0; k < 3; k++) begin
          frame[prox_enc_pkg::FRAME_BITS-1-pos] = field[g+k];
          pos++;
        end
        frame[prox_enc_pkg::FRAME_BITS-1-pos] = ~(field[g] ^ field[g+1] ^ field[g+2]);
        pos++;
      end
      r.used_format       = fmt_used[5:0];
      r.frame_word_first  = frame[95:64];
      r.frame_word_middle = frame[63:32];
      r.frame_word_last   = frame[31:0];
      return r;
    endfunction

    function void note_request(logic [7:0] fmt, logic [31:0] fc, logic [31:0] cn);
      expected_frames.push_back(encode_frame(fmt, fc, cn));
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(prox_enc_pkg::rsp_t got);
      prox_enc_pkg::rsp_t want;
      if (expected_frames.size() == 0) begin
        flag("result with no request pending", '0, got.frame_word_first);
        return;
      end
      want = expected_frames.pop_front();
      if (got.used_format !== want.used_format)
        flag("used_format", 32'(want.used_format), 32'(got.used_format));
      if (got.frame_word_first !== want.frame_word_first)
        flag("frame_word_first", want.frame_word_first, got.frame_word_first);
      if (got.frame_word_middle !== want.frame_word_middle)
        flag("frame_word_middle", want.frame_word_middle, got.frame_word_middle);
      if (got.frame_word_last !== want.frame_word_last)
        flag("frame_word_last", want.frame_word_last, got.frame_word_last);
    endfunction

    function void check_drained();
      if (expected_frames.size() != 0)
        flag("results still outstanding", '0, 32'(expected_frames.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  format_length;
  logic [31:0] facility;
  logic [31:0] card_number;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  used_format;
  logic [31:0] frame_word_first;
  logic [31:0] frame_word_middle;
  logic [31:0] frame_word_last;

  frame_scoreboard sb;
  bit              no_idle;
  bit              holdoff_req;
  int              cycles;

  always #5 clk = ~clk;

  prox_card_frame_encoder u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .format_length     (format_length),
    .facility          (facility),
    .card_number       (card_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .used_format       (used_format),
    .frame_word_first  (frame_word_first),
    .frame_word_middle (frame_word_middle),
    .frame_word_last   (frame_word_last)
  );

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_request(input logic [7:0] fmt, input logic [31:0] fc,
                              input logic [31:0] cn);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid      <= 1'b1;
    format_length <= fmt;
    facility      <= fc;
    card_number   <= cn;
    do @(posedge clk); while (!in_ready);
    sb.note_request(fmt, fc, cn);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_format();
    case ($urandom_range(9))
      0, 1:    return prox_enc_pkg::FMT_26;
      2, 3:    return prox_enc_pkg::FMT_34;
      4, 5:    return prox_enc_pkg::FMT_37;
      6, 7:    return prox_enc_pkg::FMT_50;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Result side: check accepted results, randomize ready, hold off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result('{used_format, frame_word_first, frame_word_middle, frame_word_last});
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] fmts [4];
    sb            = new();
    fmts          = '{prox_enc_pkg::FMT_26, prox_enc_pkg::FMT_34,
                      prox_enc_pkg::FMT_37, prox_enc_pkg::FMT_50};
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    format_length <= '0;
    facility      <= '0;
    card_number   <= '0;
    out_ready     <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each format at zero, all ones and alternating bits; unknown formats
    foreach (fmts[i]) begin
      send_request(fmts[i], 32'h0000_0000, 32'h0000_0000);
      send_request(fmts[i], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(fmts[i], 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(fmts[i], 32'h5555_5555, 32'hAAAA_AAAA);
    end
    send_request(8'd0, 32'h0000_00FF, 32'h0000_FFFF);
    send_request(8'd255, 32'hFFFF_FF00, 32'hFFFF_0000);
    send_request(8'd35, 32'h1234_5678, 32'h9ABC_DEF0);
    send_request(8'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(8'd178, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_drained();
    @(posedge clk);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) holdoff_req = 1'b1;
      if (i == 600) no_idle = 1'b1;
      if (i == 800) no_idle = 1'b0;
      if (i == 1000) begin
        wait_drained();
        @(posedge clk);
      end
      send_request(pick_format(), pick_value(), pick_value());
    end
    wait_drained();
    repeat (10) @(posedge clk);
    sb.check_drained();

    if (sb.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: prox_card_frame_encoder.f
+incdir+rtl/core
rtl/core/prox_enc_pkg.sv
rtl/core/prox_enc_frame.sv
rtl/core/prox_card_frame_encoder.sv
tb/sv/prox_card_frame_encoder_tb.sv
